// ===== src/q6dp_pkg.sv =====
// Shared types, constants and fp32 helpers for the q6 block dot product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q6dp_pkg;

    localparam int ELEMS_PER_ITEM = 4;
    localparam int CODE_OFFSET    = 32;
    localparam int PROD_W         = 14;  // one signed 7b weight times int8 activation
    localparam int ISUM_W         = 16;  // four lane products
    localparam int PART_W         = 20;  // sub-block partial at up to 64 elements

    typedef logic [31:0] fp32_t;

    typedef struct packed {
        logic signed [7:0] sub_scale;
        logic [15:0]       super_scale_half;
        logic [15:0]       act_scale_half;
        logic              last;
    } fold_ctl_t;

    // Widen fp16 to fp32 exactly; subnormals normalized.
    function automatic fp32_t half_to_single(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [7:0] e;
        int         lz;
        fp32_t      r;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        lz  = 0;
        for (int i = 0; i < 10; i++) begin
            if (man[9 - i] && lz == 0) begin
                lz = i + 1;
            end
        end
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                r = {s, 31'd0};
            end else begin
                e   = 8'(113 - lz);
                man = 10'(man << lz);
                r   = {s, e, man, 13'd0};
            end
        end else if (ex == 5'h1F) begin
            r = {s, 8'hFF, man, 13'd0};
        end else begin
            r = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

    // Exact integer (|v| < 2^24) to fp32.
    function automatic fp32_t int_to_single(input logic signed [31:0] v);
        logic        s;
        logic [31:0] m;
        int          msb;
        fp32_t       r;
        s   = v[31];
        m   = s ? 32'(-v) : 32'(v);
        msb = 0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                msb = i;
            end
        end
        if (m == 32'd0) begin
            r = 32'd0;
        end else begin
            m = 32'(m << (23 - msb));
            r = {s, 8'(127 + msb), m[22:0]};
        end
        return r;
    endfunction

    // Round-to-nearest-even pack of sign, unbiased exponent, 48b significand
    // with leading one at bit 47 (or zero), plus sticky.
    function automatic fp32_t round_pack(input logic s, input logic signed [11:0] ue,
                                         input logic [49:0] sig);
        logic [49:0]        m;
        logic signed [11:0] be;
        logic [24:0]        k;
        logic               g;
        logic               st;
        int                 sh;
        fp32_t              r;
        be = ue + 12'sd127;
        m  = sig;
        if (be < 12'sd1) begin
            sh = 1 - int'(be);
            if (sh > 49) begin
                sh = 49;
            end
            st = 1'b0;
            for (int i = 0; i < 50; i++) begin
                if (i < sh && m[i]) begin
                    st = 1'b1;
                end
            end
            m  = (m >> sh) | {49'd0, st};
            be = 12'sd0;
        end
        // m: bit47 leading, keep 24 bits [47:24], guard 23, sticky below
        k  = {1'b0, m[47:24]};
        g  = m[23];
        st = |m[22:0];
        if (g && (st || k[0])) begin
            k = k + 25'd1;
        end
        if (k[24]) begin
            k  = k >> 1;
            be = be + 12'sd1;
        end else if (be == 12'sd0 && k[23]) begin
            be = 12'sd1;
        end
        if (be >= 12'sd255) begin
            r = {s, 8'hFF, 23'd0};
        end else begin
            r = {s, be[7:0], k[22:0]};
        end
        return r;
    endfunction

    function automatic logic is_nan(input fp32_t a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input fp32_t a);
        return a[30:23] == 8'hFF && a[22:0] == 23'd0;
    endfunction

    function automatic fp32_t quiet(input fp32_t a);
        return a | 32'h0040_0000;
    endfunction

    // fp32 multiply, round to nearest even.
    function automatic fp32_t fp_mul(input fp32_t a, input fp32_t b);
        logic               s;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic [47:0]        p;
        logic [49:0]        sig;
        logic signed [11:0] ue;
        int                 lz;
        fp32_t              r;
        s  = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? -12'sd126 : 12'(a[30:23]) - 12'sd127;
        eb = (b[30:23] == 8'd0) ? -12'sd126 : 12'(b[30:23]) - 12'sd127;
        if (is_nan(a)) begin
            r = quiet(a);
        end else if (is_nan(b)) begin
            r = quiet(b);
        end else if (is_inf(a) || is_inf(b)) begin
            if (ma == 24'd0 && !is_inf(a) || mb == 24'd0 && !is_inf(b)) begin
                r = 32'hFFC0_0000;
            end else begin
                r = {s, 8'hFF, 23'd0};
            end
        end else begin
            p = ma * mb;
            if (p == 48'd0) begin
                r = {s, 31'd0};
            end else begin
                // product point is at bit 46
                ue = ea + eb + 12'sd1;
                lz = 0;
                for (int i = 0; i < 48; i++) begin
                    if (p[47 - i] && lz == 0) begin
                        lz = i + 1;
                    end
                end
                lz  = lz - 1;
                sig = {2'b00, 48'(p << lz)};
                ue  = ue - 12'(lz);
                r   = round_pack(s, ue, sig);
            end
        end
        return r;
    endfunction

    // fp32 add, round to nearest even.
    function automatic fp32_t fp_add(input fp32_t a, input fp32_t b);
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic [49:0]        xa;
        logic [49:0]        xb;
        logic [49:0]        sum;
        logic               st;
        logic               s;
        int                 d;
        int                 lz;
        logic signed [11:0] ue;
        fp32_t              r;
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? -12'sd126 : 12'(a[30:23]) - 12'sd127;
        eb = (b[30:23] == 8'd0) ? -12'sd126 : 12'(b[30:23]) - 12'sd127;
        if (is_nan(a)) begin
            r = quiet(a);
        end else if (is_nan(b)) begin
            r = quiet(b);
        end else if (is_inf(a) && is_inf(b)) begin
            r = (a[31] == b[31]) ? a : 32'hFFC0_0000;
        end else if (is_inf(a)) begin
            r = a;
        end else if (is_inf(b)) begin
            r = b;
        end else begin
            if (ea < eb || (ea == eb && ma < mb)) begin
                {ma, mb} = {mb, ma};
                {ea, eb} = {eb, ea};
                s = b[31];
                st = a[31];
            end else begin
                s = a[31];
                st = b[31];
            end
            // st holds the smaller operand's sign for now
            xa = {2'b00, ma, 24'd0};
            xb = {2'b00, mb, 24'd0};
            d  = int'(ea - eb);
            if (d > 49) begin
                d = 49;
            end
            lz = 0;
            for (int i = 0; i < 50; i++) begin
                if (i < d && xb[i]) begin
                    lz = 1;
                end
            end
            xb = (xb >> d) | {49'd0, lz[0]};
            if (s == st) begin
                sum = xa + xb;
            end else begin
                sum = xa - xb;
            end
            if (sum == 50'd0) begin
                r = {a[31] & b[31], 31'd0};
            end else begin
                // leading one nominally at bit 47
                ue = ea;
                if (sum[48]) begin
                    sum = (sum >> 1) | {49'd0, sum[0]};
                    ue  = ue + 12'sd1;
                end else begin
                    lz = 0;
                    for (int i = 0; i < 48; i++) begin
                        if (sum[47 - i] && lz == 0) begin
                            lz = i + 1;
                        end
                    end
                    lz  = lz - 1;
                    sum = 50'(sum << lz);
                    ue  = ue - 12'(lz);
                end
                r = round_pack(s, ue, sum);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/q6dp_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given payload width.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface q6dp_stream_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/q6dp_lane.sv =====
// One lane: rebuilds a 6-bit code, offsets it and multiplies by an activation.
// Depends on q6dp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q6dp_lane (
    input  wire logic [3:0]                          nibble,
    input  wire logic [1:0]                          high_bits,
    input  wire logic signed [7:0]                   activation,
    output logic signed [q6dp_pkg::PROD_W-1:0]       product
);
    import q6dp_pkg::*;
    logic signed [6:0] weight;
    assign weight  = $signed({1'b0, high_bits, nibble}) - 7'sd32;
    assign product = PROD_W'(weight * activation);
endmodule
`default_nettype wire

// ===== src/q6dp_fold.sv =====
// Fold unit: scales the sub-block partial and adds it to the fp32 sum,
// one rounded step per cycle. Depends on q6dp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q6dp_fold (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire q6dp_pkg::fold_ctl_t                 ctl,
    input  wire logic signed [q6dp_pkg::PART_W-1:0]  partial,
    output logic                                     busy,
    output logic                                     done,
    output logic                                     done_last,
    output q6dp_pkg::fp32_t                          acc
);
    import q6dp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SC   = 4'b0010,
        S_T    = 4'b0100,
        S_ADD  = 4'b1000
    } fold_state_t;

    fold_state_t state_reg, state_next;
    fp32_t       t_reg, t_next;
    fp32_t       act_reg;
    fp32_t       pf_reg;
    fp32_t       acc_reg, acc_next;
    logic        last_reg;
    logic        done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next     = fp_mul(int_to_single(32'(ctl.sub_scale)),
                                        half_to_single(ctl.super_scale_half));
                    state_next = S_SC;
                end
            end
            S_SC:
            begin
                t_next     = fp_mul(t_reg, pf_reg);
                state_next = S_T;
            end
            S_T:
            begin
                t_next     = fp_mul(t_reg, act_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next   = fp_add(acc_reg, t_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            // clear the sum once the final fold has been shown
            acc_reg   <= (done_reg && last_reg) ? '0 : acc_next;
            if (state_reg == S_IDLE && start)
            begin
                last_reg <= ctl.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (state_reg == S_IDLE && start)
        begin
            act_reg <= half_to_single(ctl.act_scale_half);
            pf_reg  <= int_to_single(32'(partial));
        end
    end

    assign busy      = state_reg != S_IDLE || done_reg;
    assign done      = done_reg;
    assign done_last = done_reg && last_reg;
    assign acc       = acc_reg;

`ifndef SYNTHESIS
    a_done_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD |=> done_reg)
        else $error("fold done missing after add");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("fold done while busy");
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && last_reg |=> acc_reg == '0)
        else $error("sum not cleared after last fold");
`endif
endmodule
`default_nettype wire

// ===== src/q6_block_dot_product_top.sv =====
// q6 block dot product: unpacks 6-bit weights into four lanes,
// merges lane products into an integer partial, and folds it in fp32.
// Depends on q6dp_pkg, q6dp_stream_if, q6dp_lane and q6dp_fold.
//
// Use: in_item carries four elements per item (packed fields, see port
// map); out_item carries the fp32 result of a dot product, one item per
// item flagged last. Items inside a sub-block are taken one per cycle
// while no result waits in the output register; the four lanes and the
// merging adder finish in the accept cycle. An item that ends a sub-block
// or a vector starts a fold of rounded fp32 steps (scale*super, *partial,
// *act, add), then the fold shows done; until that is over no item is
// taken. The result passes from the fold's done register into the output
// register and stays until taken; while it waits, no new item is accepted.
// Reset clears position, partial and fp32 sum to +0.0 and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none
module q6_block_dot_product_top #(
    parameter int SUBBLOCK_ELEMS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    q6dp_stream_if.sink   in_item,
    q6dp_stream_if.source out_item
);
    import q6dp_pkg::*;

    localparam int IPS_RAW = SUBBLOCK_ELEMS / ELEMS_PER_ITEM;
    localparam int IPS     = (IPS_RAW == 0) ? 1 : IPS_RAW;
    localparam int POS_W   = (IPS > 1) ? $clog2(IPS) : 1;

    logic [7:0]        lo0, lo1, hb;
    logic signed [7:0] act [ELEMS_PER_ITEM];
    logic              last;
    fold_ctl_t         ctl;

    // data layout, lsb first: ql0, ql1, qh, a0..a3, scale, super, act, last
    assign lo0    = in_item.data[7:0];
    assign lo1    = in_item.data[15:8];
    assign hb     = in_item.data[23:16];
    assign act[0] = in_item.data[31:24];
    assign act[1] = in_item.data[39:32];
    assign act[2] = in_item.data[47:40];
    assign act[3] = in_item.data[55:48];
    assign ctl.sub_scale        = in_item.data[63:56];
    assign ctl.super_scale_half = in_item.data[79:64];
    assign ctl.act_scale_half   = in_item.data[95:80];
    assign last                 = in_item.data[96];
    assign ctl.last             = last;

    logic [3:0] nib [ELEMS_PER_ITEM];
    assign nib[0] = lo0[3:0];
    assign nib[1] = lo0[7:4];
    assign nib[2] = lo1[3:0];
    assign nib[3] = lo1[7:4];

    logic signed [PROD_W-1:0] prod [ELEMS_PER_ITEM];

    for (genvar e = 0; e < ELEMS_PER_ITEM; e++)
    begin : g_lane
        q6dp_lane u_lane (
            .nibble     (nib[e]),
            .high_bits  (hb[2*e +: 2]),
            .activation (act[e]),
            .product    (prod[e])
        );
    end

    logic signed [ISUM_W-1:0] isum;
    assign isum = ISUM_W'(prod[0]) + ISUM_W'(prod[1]) + ISUM_W'(prod[2]) + ISUM_W'(prod[3]);

    logic [POS_W-1:0]         pos_reg;
    logic signed [PART_W-1:0] part_reg;
    logic signed [PART_W-1:0] part_sum;
    logic                     fold_busy, fold_done, fold_last;
    fp32_t                    fold_acc;
    logic                     out_valid_reg;
    fp32_t                    out_data_reg;
    logic                     accept, at_end, fold_start;

    assign in_item.ready = !fold_busy && !out_valid_reg;
    assign accept        = in_item.valid && in_item.ready;
    assign part_sum      = part_reg + PART_W'(isum);
    assign at_end        = 32'(pos_reg) == IPS - 1;
    assign fold_start    = accept && (at_end || last);

    q6dp_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fold_start),
        .ctl       (ctl),
        .partial   (part_sum),
        .busy      (fold_busy),
        .done      (fold_done),
        .done_last (fold_last),
        .acc       (fold_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            part_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (fold_start)
                begin
                    pos_reg  <= '0;
                    part_reg <= '0;
                end
                else
                begin
                    pos_reg  <= pos_reg + 1'b1;
                    part_reg <= part_sum;
                end
            end
            if (fold_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_last)
        begin
            out_data_reg <= fold_acc;
        end
    end

    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fold_busy |-> !accept)
        else $error("item taken during fold");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < IPS)
        else $error("position out of range");
    a_fold_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fold_start |=> pos_reg == '0 && part_reg == '0)
        else $error("partial not cleared at fold");
    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        fold_last |-> fold_done)
        else $error("final fold shown without done");
`endif
endmodule
`default_nettype wire
